>>> src/prmt_pkg.sv
// ----------------------------------------------------------------------------
// prmt_pkg: types and codes of the process region map table
// Item structs, command and status codes shared by the table.
// ----------------------------------------------------------------------------
package prmt_pkg;

    localparam int PidW  = 22;
    localparam int AddrW = 64;
    localparam int AgeW  = 16;

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_FIND_ADR = 3'd2,
        CMD_FIND_HDL = 3'd3,
        CMD_DROP     = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_NOSPACE  = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [PidW-1:0]  pid;
        logic [AddrW-1:0] start_address;
        logic [AddrW-1:0] end_address;
        logic [AddrW-1:0] page_offset;
        logic [AddrW-1:0] user_handle;
        logic [AddrW-1:0] probe_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [AddrW-1:0] found_start;
        logic [AddrW-1:0] found_end;
        logic [AddrW-1:0] found_offset;
        logic [AddrW-1:0] found_handle;
    } t_out_item;

    // one stored region record
    typedef struct packed {
        logic [PidW-1:0]  pid;
        logic [AddrW-1:0] start_a;
        logic [AddrW-1:0] end_a;
        logic [AddrW-1:0] offs;
        logic [AddrW-1:0] handle;
        logic [AgeW-1:0]  age;
    } t_entry;

endpackage

>>> src/process_region_map_table_core.sv
// ----------------------------------------------------------------------------
// process_region_map_table_core: process region map table
// Pool of region records in one synchronous memory, searched by a scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall carries one command item (add, remove,
//   find by address, find by handle, drop pid). Output channel
//   o_valid/i_stall returns exactly one result item per command.
//   Each item is handled by one scan over the record memory, one read per
//   cycle, followed by at most one write back (or a write per entry during
//   drop, done in the same scan). The block takes a new item only after
//   the previous one has passed its scan, write and done states; the
//   single read port of the record memory sets this. Valid bits live in
//   flip-flops and clear at reset, so no clearing pass is needed; the
//   block accepts items right after reset. The result sits in an output
//   register; the next item is accepted while it waits, and the block only
//   holds at the end of a scan when a new result is ready but the previous
//   one has not been taken. A stalled result holds its value.
// ----------------------------------------------------------------------------
module process_region_map_table_core #(
    parameter int ENTRIES = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  prmt_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output prmt_pkg::t_out_item o_item
);
    import prmt_pkg::*;

    localparam int IdxW = $clog2(ENTRIES);
    localparam int CntW = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // record store and valid bits
    t_entry r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_vld;
    t_entry r_rd;

    t_state r_state, n_state;
    t_in_item r_cmd;
    logic [CntW-1:0] r_addr;      // read address counter
    logic [IdxW-1:0] r_ridx;      // index of data in r_rd
    logic r_rvalid;               // r_rd holds a scanned entry
    logic r_best_ok;
    logic [IdxW-1:0] r_best;
    logic [AgeW-1:0] r_best_d;
    t_entry r_best_e;
    logic r_free_ok;
    logic [IdxW-1:0] r_free;
    logic [AgeW-1:0] r_stamp;
    logic r_ovalid, n_ovalid;
    t_out_item r_out, n_out;

    // scan compare on the entry read last cycle
    logic e_live, hit;
    logic [AgeW-1:0] age_d;
    always_comb begin
        e_live = r_rvalid && r_vld[r_ridx];
        age_d = r_stamp - r_rd.age;
        hit = 1'b0;
        if (e_live && r_rd.pid == r_cmd.pid) begin
            case (r_cmd.cmd)
                CMD_ADD, CMD_REMOVE: hit = r_rd.start_a == r_cmd.start_address;
                CMD_FIND_ADR: hit = r_cmd.probe_address >= r_rd.start_a
                                    && r_cmd.probe_address < r_rd.end_a;
                CMD_FIND_HDL: hit = r_rd.handle == r_cmd.user_handle;
                default: hit = 1'b0;
            endcase
        end
    end

    // result of the finished scan, stable while in S_DONE
    always_comb begin
        n_out = '0;
        case (r_cmd.cmd)
            CMD_ADD: begin
                if (r_best_ok) n_out.status = ST_BUSY;
                else if (!r_free_ok) n_out.status = ST_NOSPACE;
            end
            CMD_REMOVE: begin
                if (!r_best_ok) n_out.status = ST_NOTFOUND;
            end
            CMD_FIND_ADR, CMD_FIND_HDL: begin
                if (r_best_ok) begin
                    n_out.found_start = r_best_e.start_a;
                    n_out.found_end = r_best_e.end_a;
                    n_out.found_offset = r_best_e.offs;
                    if (r_cmd.cmd == CMD_FIND_ADR)
                        n_out.found_handle = r_best_e.handle;
                end else n_out.status = ST_NOTFOUND;
            end
            default: ;
        endcase
    end

    // output valid: set when a result is loaded, cleared when taken
    always_comb begin
        n_ovalid = r_ovalid;
        if (r_state == S_DONE && (!r_ovalid || !i_stall)) n_ovalid = 1'b1;
        else if (r_ovalid && !i_stall) n_ovalid = 1'b0;
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_ovalid;
    assign o_item = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_SCAN;
            S_SCAN: if (!r_rvalid && r_addr == CntW'(ENTRIES)) n_state = S_WRITE;
            S_WRITE: n_state = S_DONE;
            S_DONE: if (!r_ovalid || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory read port and write of an added record
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_addr[IdxW-1:0]];
        if (r_state == S_WRITE && r_cmd.cmd == CMD_ADD && !r_best_ok && r_free_ok) begin
            r_mem[r_free] <= '{pid: r_cmd.pid, start_a: r_cmd.start_address,
                              end_a: r_cmd.end_address, offs: r_cmd.page_offset,
                              handle: r_cmd.user_handle, age: r_stamp};
        end
    end

    // control and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld <= '0;
            r_stamp <= '0;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
            r_addr <= '0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            case (r_state)
                S_IDLE: begin
                    r_cmd <= i_item;
                    r_addr <= '0;
                    r_rvalid <= 1'b0;
                    r_best_ok <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_best <= '0;
                    r_best_d <= '0;
                    r_free <= '0;
                end
                S_SCAN: begin
                    r_rvalid <= r_addr < CntW'(ENTRIES);
                    r_ridx <= r_addr[IdxW-1:0];
                    if (r_addr < CntW'(ENTRIES)) r_addr <= r_addr + 1'b1;
                    if (r_rvalid) begin
                        if (hit && (!r_best_ok || age_d < r_best_d)) begin
                            r_best_ok <= 1'b1;
                            r_best <= r_ridx;
                            r_best_d <= age_d;
                            r_best_e <= r_rd;
                        end
                        if (!r_vld[r_ridx] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free <= r_ridx;
                        end
                        if (r_cmd.cmd == CMD_DROP && e_live && r_rd.pid == r_cmd.pid)
                            r_vld[r_ridx] <= 1'b0;
                    end
                end
                S_WRITE: begin
                    if (r_cmd.cmd == CMD_ADD && !r_best_ok && r_free_ok) begin
                        r_vld[r_free] <= 1'b1;
                        r_stamp <= r_stamp + 1'b1;
                    end
                    if (r_cmd.cmd == CMD_REMOVE && r_best_ok) r_vld[r_best] <= 1'b0;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) r_out <= n_out;
                end
                default: ;
            endcase
        end
    end

    // checks
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_ovalid && i_stall |=> r_state == S_DONE)
        else $error("result overwritten while stalled");
    a_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_WRITE |=> $stable(r_stamp)) else $error("stamp moved");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && i_valid |=> r_state == S_SCAN)
        else $error("accept lost");

endmodule

>>> verif/process_region_map_table_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// process_region_map_table_core_checker: result checker for the region table
// Watches both channels, keeps a shadow region pool, predicts one result per
// accepted command item and compares it field by field with the block.
// ----------------------------------------------------------------------------
module process_region_map_table_core_checker
    import prmt_pkg::*;
#(
    parameter int ENTRIES = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending
);

    // shadow pool
    logic             pool_valid [ENTRIES];
    logic [PidW-1:0]  pool_pid   [ENTRIES];
    logic [AddrW-1:0] pool_start [ENTRIES];
    logic [AddrW-1:0] pool_end   [ENTRIES];
    logic [AddrW-1:0] pool_offs  [ENTRIES];
    logic [AddrW-1:0] pool_hdl   [ENTRIES];
    logic [AgeW-1:0]  pool_age   [ENTRIES];
    logic [AgeW-1:0]  stamp;

    t_out_item expected_results[$];

    // newest matching entry; mode 0 key start, 1 address inside, 2 handle
    function automatic int newest_match(logic [PidW-1:0] pid, int mode,
                                        logic [AddrW-1:0] key);
        int best;
        logic [AgeW-1:0] best_dist;
        logic [AgeW-1:0] age_d;
        logic hit;
        best = -1;
        best_dist = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!pool_valid[i] || pool_pid[i] != pid) continue;
            if (mode == 0) hit = (pool_start[i] == key);
            else if (mode == 1) hit = (key >= pool_start[i]) && (key < pool_end[i]);
            else hit = (pool_hdl[i] == key);
            if (hit) begin
                age_d = stamp - pool_age[i];
                if (best < 0 || age_d < best_dist) begin
                    best = i;
                    best_dist = age_d;
                end
            end
        end
        return best;
    endfunction

    // apply one command to the shadow pool, return its result
    function automatic t_out_item apply_command(t_in_item it);
        t_out_item r;
        int hit;
        r = '0;
        r.status = ST_OK;
        case (it.cmd)
            CMD_ADD: begin
                if (newest_match(it.pid, 0, it.start_address) >= 0) begin
                    r.status = ST_BUSY;
                end else begin
                    hit = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (hit < 0 && !pool_valid[i]) hit = i;
                    if (hit < 0) begin
                        r.status = ST_NOSPACE;
                    end else begin
                        pool_valid[hit] = 1'b1;
                        pool_pid[hit]   = it.pid;
                        pool_start[hit] = it.start_address;
                        pool_end[hit]   = it.end_address;
                        pool_offs[hit]  = it.page_offset;
                        pool_hdl[hit]   = it.user_handle;
                        pool_age[hit]   = stamp;
                        stamp = stamp + 1'b1;
                    end
                end
            end
            CMD_REMOVE: begin
                hit = newest_match(it.pid, 0, it.start_address);
                if (hit < 0) r.status = ST_NOTFOUND;
                else pool_valid[hit] = 1'b0;
            end
            CMD_FIND_ADR, CMD_FIND_HDL: begin
                if (it.cmd == CMD_FIND_ADR)
                    hit = newest_match(it.pid, 1, it.probe_address);
                else
                    hit = newest_match(it.pid, 2, it.user_handle);
                if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.found_start  = pool_start[hit];
                    r.found_end    = pool_end[hit];
                    r.found_offset = pool_offs[hit];
                    if (it.cmd == CMD_FIND_ADR) r.found_handle = pool_hdl[hit];
                end
            end
            CMD_DROP: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (pool_valid[i] && pool_pid[i] == it.pid) pool_valid[i] = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [AddrW-1:0] got,
                                   logic [AddrW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) pool_valid[i] = 1'b0;
            stamp = '0;
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result status",
                                    AddrW'(i_out_item.status), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.status !== want.status)
                        report_mismatch("status", AddrW'(i_out_item.status),
                                        AddrW'(want.status));
                    if (i_out_item.found_start !== want.found_start)
                        report_mismatch("found_start", i_out_item.found_start,
                                        want.found_start);
                    if (i_out_item.found_end !== want.found_end)
                        report_mismatch("found_end", i_out_item.found_end,
                                        want.found_end);
                    if (i_out_item.found_offset !== want.found_offset)
                        report_mismatch("found_offset", i_out_item.found_offset,
                                        want.found_offset);
                    if (i_out_item.found_handle !== want.found_handle)
                        report_mismatch("found_handle", i_out_item.found_handle,
                                        want.found_handle);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(apply_command(i_in_item));
        end
        o_pending = expected_results.size();
    end

endmodule

>>> verif/process_region_map_table_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// process_region_map_table_core_test: testbench top of the region table
// Drives directed and random command items with random idling on both
// sides, a long receiver hold-off and a drain pause; the checker predicts.
// ----------------------------------------------------------------------------
module process_region_map_table_core_test;
    import prmt_pkg::*;

    localparam int ENTRIES   = 128;
    localparam int IDLE_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        error_count;
    int        pending;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  idle_cycles;

    // small key pools so adds, removes and finds collide
    logic [PidW-1:0]  pid_pool   [4];
    logic [AddrW-1:0] start_pool [8];
    logic [AddrW-1:0] hdl_pool   [4];

    process_region_map_table_core #(.ENTRIES(ENTRIES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_item  (out_item)
    );

    process_region_map_table_core_checker #(.ENTRIES(ENTRIES)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_errors    (error_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [AddrW-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offer one item, hold it until taken, then maybe idle
    task automatic send_item(t_in_item it);
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic t_in_item make_item(t_cmd c, logic [PidW-1:0] p,
                                           logic [AddrW-1:0] s, logic [AddrW-1:0] e,
                                           logic [AddrW-1:0] h, logic [AddrW-1:0] pr);
        t_in_item it;
        it.cmd = c;
        it.pid = p;
        it.start_address = s;
        it.end_address = e;
        it.page_offset = rand64();
        it.user_handle = h;
        it.probe_address = pr;
        return it;
    endfunction

    // mostly well-formed commands over small key pools, some noise
    function automatic t_in_item random_item();
        t_in_item it;
        int sel;
        int k;
        logic [AddrW-1:0] s;
        sel = $urandom_range(99);
        k = $urandom_range(7);
        s = start_pool[k];
        it = make_item(CMD_ADD, pid_pool[$urandom_range(3)], s,
                       s + AddrW'($urandom_range(4096)), hdl_pool[$urandom_range(3)],
                       s + AddrW'($urandom_range(4096)));
        if (sel < 35) it.cmd = CMD_ADD;
        else if (sel < 50) it.cmd = CMD_REMOVE;
        else if (sel < 72) it.cmd = CMD_FIND_ADR;
        else if (sel < 88) it.cmd = CMD_FIND_HDL;
        else if (sel < 92) it.cmd = CMD_DROP;
        else begin
            it.cmd = 3'($urandom_range(7));
            it.pid = PidW'($urandom);
            it.start_address = rand64();
            it.end_address = rand64();
            it.user_handle = rand64();
            it.probe_address = rand64();
        end
        if ($urandom_range(9) == 0) it.end_address = rand64();
        return it;
    endfunction

    // stop offering and wait for every expected result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (ENTRIES + 8) @(posedge i_clk);
    endtask

    // receiver stall, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) out_stall <= 1'b0;
        else if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        logic [PidW-1:0] full_pid;
        in_valid = 1'b0;
        in_item = '0;
        i_rst_n = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (pid_pool[i]) pid_pool[i] = PidW'($urandom);
        pid_pool[0] = '0;
        pid_pool[1] = '1;
        foreach (start_pool[i]) start_pool[i] = rand64();
        start_pool[0] = '0;
        start_pool[1] = {AddrW{1'b1}} - 64'd4096;
        foreach (hdl_pool[i]) hdl_pool[i] = rand64();
        hdl_pool[0] = '1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every command, special cases
        send_item(make_item(CMD_ADD, '1, '0, '1, '1, '0));
        send_item(make_item(CMD_ADD, '1, '0, 64'd5, 64'd1, '0));           // duplicate
        send_item(make_item(CMD_ADD, '1, 64'd100, 64'd100, 64'd2, '0));    // empty region
        send_item(make_item(CMD_ADD, '1, 64'd10, 64'd50, 64'd1, '0));
        send_item(make_item(CMD_FIND_ADR, '1, '0, '0, '0, 64'd20));       // newest wins
        send_item(make_item(CMD_FIND_ADR, '1, '0, '0, '0, 64'd100));      // empty no hit
        send_item(make_item(CMD_FIND_ADR, '1, '0, '0, '0, '1));
        send_item(make_item(CMD_FIND_HDL, '1, '0, '0, '1, '0));
        send_item(make_item(CMD_FIND_HDL, '1, '0, '0, 64'd1, '0));
        send_item(make_item(CMD_FIND_HDL, '0, '0, '0, 64'd1, '0));        // wrong pid
        send_item(make_item(CMD_REMOVE, '1, 64'd10, '0, '0, '0));
        send_item(make_item(CMD_REMOVE, '1, 64'd10, '0, '0, '0));         // miss
        send_item(make_item(CMD_DROP, '0, '0, '0, '0, '0));               // nothing matched
        send_item(make_item(CMD_DROP, '1, '0, '0, '0, '0));
        it = '1;                                                          // unused command
        send_item(it);
        it.cmd = 3'd5;
        send_item(it);
        // fill the pool, then one more
        full_pid = 22'h155555;
        for (int i = 0; i <= ENTRIES; i++)
            send_item(make_item(CMD_ADD, full_pid, AddrW'(i), AddrW'(i + 2),
                                AddrW'(i), AddrW'(i)));
        send_item(make_item(CMD_FIND_ADR, full_pid, '0, '0, '0, 64'd3));
        send_item(make_item(CMD_DROP, full_pid, '0, '0, '0, '0));

        // random phases with changing idling
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 50 : 0;
            recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 21 : 0;
            for (int n = 0; n < 400; n++) begin
                if (ph == 2 && n == 100) begin
                    // long hold-off: the block fills and stalls its input
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (3 * (ENTRIES + 3)) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                if (n == 300) drain();
                send_item(random_item());
            end
        end

        drain();
        if (error_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/prmt_pkg.sv
src/process_region_map_table_core.sv
verif/process_region_map_table_core_checker.sv
verif/process_region_map_table_core_test.sv
